/* sv/nms_pkg.sv */
// shared types, constants and the strict-maximum function of the 3x3 suppressor
package nms_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4095;
  localparam int SAMPLE_BITS    = 24;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = 12;
  localparam int WIDTH_REG_BITS = 11;
  localparam int CFG_BITS       = 12;
  localparam int CFG_IDX_BITS   = 1;
  localparam int LINE_BITS      = 2 * SAMPLE_BITS;
  localparam int NUM_RES        = 4;
  localparam int RES_IDX_BITS   = $clog2(NUM_RES);
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // window indexed [row][col], row 2 and col 2 are the newest
  typedef logic [2:0][2:0][SAMPLE_BITS-1:0] win_t;

  // one pixel on its way from the input to the window
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                r_ge1;
    logic                r_ge2;
    logic                c_ge1;
    logic                c_ge2;
    logic                last_col;
    logic                last_row;
  } item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]    row;
    logic [COL_BITS-1:0]    col;
    logic [SAMPLE_BITS-1:0] value;
    logic                   peak;
  } res_t;

  typedef struct packed {
    res_t [NUM_RES-1:0] res;
    logic [NUM_RES-1:0] mask;
  } job_t;

  // cell (cr,cc) beats every cell of rows rlo..2 and cols clo..2
  function automatic logic strict_max(win_t w, logic [1:0] cr, logic [1:0] cc,
                                      logic [1:0] rlo, logic [1:0] clo);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((2'(i) >= rlo) && (2'(j) >= clo) && !((2'(i) == cr) && (2'(j) == cc))) begin
          if (w[i][j] >= w[cr][cc]) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

/* sv/nms_line_ram.sv */
// line store memory: older and newer row sample per column, registered read
module nms_line_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [nms_pkg::COL_BITS-1:0]  waddr_i,
  input  logic [nms_pkg::LINE_BITS-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [nms_pkg::COL_BITS-1:0]  raddr_i,
  output logic [nms_pkg::LINE_BITS-1:0] rdata_o
);
  import nms_pkg::*;

  logic [LINE_BITS-1:0] mem [MAX_WIDTH];
  logic [LINE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/nms_window.sv */
// 3x3 window registers and the four strict-maximum tests of one pixel
module nms_window (
  input  logic                            clk_i,
  input  logic                            go_i,
  input  nms_pkg::item_t                  item_i,
  input  logic [nms_pkg::SAMPLE_BITS-1:0] px_i,
  input  logic [nms_pkg::SAMPLE_BITS-1:0] older_i,
  input  logic [nms_pkg::SAMPLE_BITS-1:0] newer_i,
  output nms_pkg::job_t                   job_o
);
  import nms_pkg::*;

  win_t       win_q, win_d;
  logic [1:0] rlo, clo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = older_i;
    win_d[1][2] = newer_i;
    win_d[2][2] = px_i;
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      win_q <= win_d;
    end
  end

  // first window row / column lies outside the frame near the top and left edges
  assign rlo = item_i.r_ge2 ? 2'd0 : 2'd1;
  assign clo = item_i.c_ge2 ? 2'd0 : 2'd1;

  always_comb begin
    job_o.res[0].row  = item_i.row - ROW_BITS'(1);
    job_o.res[0].col  = item_i.col - COL_BITS'(1);
    job_o.res[0].peak = strict_max(win_d, 2'd1, 2'd1, rlo, clo);
    job_o.res[0].value = job_o.res[0].peak ? win_d[1][1] : '0;

    job_o.res[1].row  = item_i.row - ROW_BITS'(1);
    job_o.res[1].col  = item_i.col;
    job_o.res[1].peak = strict_max(win_d, 2'd1, 2'd2, rlo, 2'd1);
    job_o.res[1].value = job_o.res[1].peak ? win_d[1][2] : '0;

    job_o.res[2].row  = item_i.row;
    job_o.res[2].col  = item_i.col - COL_BITS'(1);
    job_o.res[2].peak = strict_max(win_d, 2'd2, 2'd1, 2'd1, clo);
    job_o.res[2].value = job_o.res[2].peak ? win_d[2][1] : '0;

    job_o.res[3].row  = item_i.row;
    job_o.res[3].col  = item_i.col;
    job_o.res[3].peak = strict_max(win_d, 2'd2, 2'd2, 2'd1, 2'd1);
    job_o.res[3].value = job_o.res[3].peak ? win_d[2][2] : '0;

    job_o.mask[0] = item_i.r_ge1 && item_i.c_ge1;
    job_o.mask[1] = item_i.r_ge1 && item_i.last_col;
    job_o.mask[2] = item_i.r_ge1 && item_i.last_row && item_i.c_ge1;
    job_o.mask[3] = item_i.r_ge1 && item_i.last_row && item_i.last_col;
  end

endmodule

/* sv/nms_emit.sv */
// result buffer: holds up to four results of one pixel and hands them out in order
module nms_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  nms_pkg::job_t                   job_i,
  output logic                            free_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nms_pkg::ROW_BITS-1:0]    out_row_o,
  output logic [nms_pkg::COL_BITS-1:0]    out_col_o,
  output logic [nms_pkg::SAMPLE_BITS-1:0] out_value_o,
  output logic                            is_peak_o,
  output logic                            run_last_o
);
  import nms_pkg::*;

  res_t [NUM_RES-1:0]    slot_q;
  logic [NUM_RES-1:0]    mask_q, mask_d;
  logic [NUM_RES-1:0]    head_bit;
  logic [RES_IDX_BITS-1:0] head;
  logic                  single;

  always_comb begin
    head = '0;
    for (int i = NUM_RES - 1; i >= 0; i--) begin
      if (mask_q[i]) head = RES_IDX_BITS'(i);
    end
  end

  assign head_bit    = mask_q & ~(mask_q - NUM_RES'(1));
  assign single      = (mask_q & ~head_bit) == '0;
  assign out_valid_o = mask_q != '0;
  assign free_o      = !out_valid_o || (single && out_ready_i);

  assign out_row_o   = slot_q[head].row;
  assign out_col_o   = slot_q[head].col;
  assign out_value_o = slot_q[head].value;
  assign is_peak_o   = slot_q[head].peak;
  assign run_last_o  = single;

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = job_i.mask;
    end else if (out_valid_o && out_ready_i) begin
      mask_d = mask_q & ~head_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= job_i.res;
    end
  end

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> out_valid_o)
    else $error("loaded results not presented");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o && out_ready_i && !load_i |=> !out_valid_o)
    else $error("results left after run_last");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !out_valid_o || (single && out_ready_i))
    else $error("results overwritten before delivery");

endmodule

/* sv/nonmax_suppress_3x3_core.sv */
// top level of the streaming 3x3 non-maximum suppressor
// A frame of unsigned 24-bit response samples enters in raster order, one request
// per pixel, and each pixel is reported as out_value = sample when it is strictly
// greater than all of its in-frame neighbours (is_peak = 1), else 0. Results carry
// their row and column: a pixel at row r, column c (r >= 1) finishes the pixel
// above-left, the pixel above when c is the last column, and on the last row also
// the pixels at (r, c-1) and (r, c); run_last marks the final result of a request.
// Row 0 and column 0 requests give no result. Throughput is one pixel per clock
// while a pixel gives at most one result and out_ready is high; a pixel at the
// end of a row gives two results and on the last row two or four, and as results
// leave one per clock while out_ready is high, such pixels hold up the input as
// they drain. A result is presented once its request leaves stage 1: the accepting
// edge starts the registered line memory read, and the edge that moves stage 1 on
// (output buffer free) shifts the window and loads the tested results into the
// output buffer. The two line stores share one 1024 x 48 memory (older row in the
// upper half), read at the incoming column and written back as the pixel leaves
// stage 1; consecutive pixels always fall in different columns, so the two never
// collide. The memory needs no clearing pass: an entry is read into a neighbour
// position inside the frame only after this frame wrote it. Any configuration
// write restarts the frame at row 0, column 0; the width is clamped to 2..1024,
// the height to 2..4095. Write configuration only while no request is in flight.
module nonmax_suppress_3x3_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nms_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [nms_pkg::CFG_BITS-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [nms_pkg::SAMPLE_BITS-1:0] pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nms_pkg::ROW_BITS-1:0]    out_row_o,
  output logic [nms_pkg::COL_BITS-1:0]    out_col_o,
  output logic [nms_pkg::SAMPLE_BITS-1:0] out_value_o,
  output logic                            is_peak_o,
  output logic                            run_last_o
);
  import nms_pkg::*;

  // configuration, kept as last column / last row index
  logic [COL_BITS-1:0]       w_last_q, w_last_d;
  logic [ROW_BITS-1:0]       h_last_q, h_last_d;
  logic [WIDTH_REG_BITS-1:0] w_raw;
  logic [ROW_BITS-1:0]       h_raw;

  // raster position of the next request
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [COL_BITS-1:0] col_q, col_d;

  // stage 1: request waiting for its line memory data
  logic                   s1_valid_q, s1_valid_d;
  item_t                  s1_q, item_in;
  logic [SAMPLE_BITS-1:0] s1_px_q;
  logic                   s1_go;

  logic                 in_acc;
  logic [LINE_BITS-1:0] line_rd;
  job_t                 job;
  logic                 emit_free;

  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  // a pixel with no result never waits on the output buffer
  assign s1_go = s1_valid_q && ((job.mask == '0) || emit_free);

  // position flags of the incoming pixel
  always_comb begin
    item_in.row      = row_q;
    item_in.col      = col_q;
    item_in.r_ge1    = row_q != '0;
    item_in.r_ge2    = row_q >= ROW_BITS'(2);
    item_in.c_ge1    = col_q != '0;
    item_in.c_ge2    = col_q >= COL_BITS'(2);
    item_in.last_col = col_q >= w_last_q;
    item_in.last_row = row_q >= h_last_q;
  end

  // clamp register values on the way in
  assign w_raw = cfg_data_i[WIDTH_REG_BITS-1:0];
  assign h_raw = cfg_data_i[ROW_BITS-1:0];

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          if (w_raw < WIDTH_REG_BITS'(2)) begin
            w_last_d = COL_BITS'(1);
          end else if (w_raw > WIDTH_REG_BITS'(MAX_WIDTH)) begin
            w_last_d = COL_BITS'(MAX_WIDTH - 1);
          end else begin
            w_last_d = COL_BITS'(w_raw - WIDTH_REG_BITS'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (h_raw < ROW_BITS'(2)) begin
            h_last_d = ROW_BITS'(1);
          end else begin
            h_last_d = h_raw - ROW_BITS'(1);
          end
        end
        default: begin
          w_last_d = w_last_q;
        end
      endcase
    end
  end

  // raster counters, restarted by any register write
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (in_acc) begin
      if (item_in.last_col) begin
        col_d = '0;
        row_d = item_in.last_row ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_d = col_q + COL_BITS'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= COL_BITS'(RESET_WIDTH - 1);
      h_last_q   <= ROW_BITS'(RESET_HEIGHT - 1);
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      w_last_q   <= w_last_d;
      h_last_q   <= h_last_d;
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q    <= item_in;
      s1_px_q <= pixel_value_i;
    end
  end

  // read at the incoming column, write back {newer -> older, pixel -> newer}
  nms_line_ram u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_q.col),
    .wdata_i ({line_rd[SAMPLE_BITS-1:0], s1_px_q}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  nms_window u_window (
    .clk_i   (clk_i),
    .go_i    (s1_go),
    .item_i  (s1_q),
    .px_i    (s1_px_q),
    .older_i (line_rd[LINE_BITS-1:SAMPLE_BITS]),
    .newer_i (line_rd[SAMPLE_BITS-1:0]),
    .job_o   (job)
  );

  nms_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_go && (job.mask != '0)),
    .job_i       (job),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .is_peak_o   (is_peak_o),
    .run_last_o  (run_last_o)
  );

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last_q)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last_q)
    else $error("row counter beyond frame height");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_q) && $stable(s1_px_q))
    else $error("stalled pixel lost or changed");

endmodule
